/* rtl/dcp_pkg.sv */
// Shared constants for the distance constraint projection pipeline.
package dcp_pkg;

    // Quotients (unit direction and mass shares) are unsigned Q1.30 and fit in 31 bits.
    localparam int QuotW = 31;
    localparam int QFrac = 30;
    localparam logic [QuotW-1:0] QOne = 31'h4000_0000;

    // Operand slice width used by the split multipliers.
    localparam int MulChunk = 24;

endpackage

/* rtl/dcp_mul.sv */
// Two-stage multi-lane multiplier built from registered partial products.
module dcp_mul import dcp_pkg::*; #(
    parameter int LANES = 3,
    parameter int AW    = 33,
    parameter int BW    = 33,
    parameter int SW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LANES*AW-1:0]   i_a,
    input  logic [LANES*BW-1:0]   i_b,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LANES*(AW+BW)-1:0] o_p,
    output logic [SW-1:0]         o_side
);

    localparam int NA = (AW + MulChunk - 1) / MulChunk;
    localparam int NB = (BW + MulChunk - 1) / MulChunk;
    localparam int PW = AW + BW;
    localparam int XW = (NA + NB) * MulChunk;

    logic                  r_v1, r_v2;
    logic                  rdy1, rdy2;
    logic [2*MulChunk-1:0] r_pp [LANES][NA][NB];
    logic [2*MulChunk-1:0] n_pp [LANES][NA][NB];
    logic [PW-1:0]         r_p  [LANES];
    logic [PW-1:0]         n_p  [LANES];
    logic [SW-1:0]         r_side1, r_side2;
    logic [NA*MulChunk-1:0] a_ext [LANES];
    logic [NB*MulChunk-1:0] b_ext [LANES];

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_side  = r_side2;

    // Zero-extend each lane operand to a whole number of slices.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign a_ext[l] = (NA*MulChunk)'(i_a[l*AW +: AW]);
        assign b_ext[l] = (NB*MulChunk)'(i_b[l*BW +: BW]);
        assign o_p[l*PW +: PW] = r_p[l];
    end

    // Slice products for the first stage.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int ja = 0; ja < NA; ja++) begin
                for (int jb = 0; jb < NB; jb++) begin
                    n_pp[l][ja][jb] = a_ext[l][ja*MulChunk +: MulChunk]
                                    * b_ext[l][jb*MulChunk +: MulChunk];
                end
            end
        end
    end

    // Weighted sum of the registered slice products.
    always_comb begin
        logic [XW-1:0] acc;
        for (int l = 0; l < LANES; l++) begin
            acc = '0;
            for (int ja = 0; ja < NA; ja++) begin
                for (int jb = 0; jb < NB; jb++) begin
                    acc = acc + (XW'(r_pp[l][ja][jb]) << ((ja + jb) * MulChunk));
                end
            end
            n_p[l] = acc[PW-1:0];
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // Payload registers load only on a transfer into the stage.
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_pp    <= n_pp;
            r_side1 <= i_side;
        end
        if (rdy2 && r_v1) begin
            r_p     <= n_p;
            r_side2 <= r_side1;
        end
    end

endmodule

/* rtl/dcp_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module dcp_isqrt #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2*RW-1:0] i_s,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic            r_v    [RW];
    logic [2*RW-1:0] r_s    [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SW-1:0]   r_side [RW];
    logic            rdy    [RW+1];

    assign rdy[RW]  = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[RW-1];
    assign o_root   = r_root[RW-1];
    assign o_side   = r_side[RW-1];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int K = RW - 1 - g;
        logic            v_in;
        logic [2*RW-1:0] s_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [SW-1:0]   side_in;
        logic [RW+1:0]   rem_sh, trial, n_rem;
        logic [RW-1:0]   n_root;
        logic            ge;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign s_in    = i_s;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign s_in    = r_s[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
        end

        assign rdy[g] = !r_v[g] || rdy[g+1];

        // Bring down the next two radicand bits and try the next root bit.
        always_comb begin
            rem_sh = {rem_in[RW-1:0], s_in[2*K+1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {root_in[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (rdy[g]) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[g] && v_in) begin
                r_s[g]    <= s_in;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= side_in;
            end
        end
    end

endmodule

/* rtl/dcp_div.sv */
// Pipelined multi-lane restoring divider giving floor(n * 2^30 / d), one bit per stage.
module dcp_div import dcp_pkg::*; #(
    parameter int LANES = 3,
    parameter int NW    = 33,
    parameter int DW    = 33,
    parameter int SW    = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [LANES*NW-1:0]    i_n,
    input  logic [DW-1:0]          i_d,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LANES*QuotW-1:0] o_q,
    output logic [SW-1:0]          o_side
);

    logic             r_v    [QuotW];
    logic [DW-1:0]    r_d    [QuotW];
    logic [DW:0]      r_rem  [QuotW][LANES];
    logic [QuotW-1:0] r_q    [QuotW][LANES];
    logic [SW-1:0]    r_side [QuotW];
    logic             rdy    [QuotW+1];

    assign rdy[QuotW] = i_ready;
    assign o_ready    = rdy[0];
    assign o_valid    = r_v[QuotW-1];
    assign o_side     = r_side[QuotW-1];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_q[l*QuotW +: QuotW] = r_q[QuotW-1][l];
    end

    for (genvar g = 0; g < QuotW; g++) begin : g_stage
        logic             v_in;
        logic [DW-1:0]    d_in;
        logic [DW:0]      rem_in [LANES];
        logic [QuotW-1:0] q_in   [LANES];
        logic             bit_in [LANES];
        logic [SW-1:0]    side_in;
        logic [DW:0]      n_rem  [LANES];
        logic [QuotW-1:0] n_q    [LANES];

        // The dividend is n shifted up by 30, so only the first step shifts in a bit of n.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (g == 0) begin : g_first
                assign rem_in[l] = (DW+1)'(i_n[l*NW +: NW] >> 1);
                assign bit_in[l] = i_n[l*NW];
                assign q_in[l]   = '0;
            end else begin : g_next
                assign rem_in[l] = r_rem[g-1][l];
                assign bit_in[l] = 1'b0;
                assign q_in[l]   = r_q[g-1][l];
            end
        end

        if (g == 0) begin : g_first_c
            assign v_in    = i_valid;
            assign d_in    = i_d;
            assign side_in = i_side;
        end else begin : g_next_c
            assign v_in    = r_v[g-1];
            assign d_in    = r_d[g-1];
            assign side_in = r_side[g-1];
        end

        assign rdy[g] = !r_v[g] || rdy[g+1];

        // Shift, compare and conditionally subtract for every lane.
        always_comb begin
            logic [DW:0] sh;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                sh       = {rem_in[l][DW-1:0], bit_in[l]};
                ge       = (sh >= {1'b0, d_in});
                n_rem[l] = ge ? (sh - {1'b0, d_in}) : sh;
                n_q[l]   = {q_in[l][QuotW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (rdy[g]) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[g] && v_in) begin
                r_d[g]    <= d_in;
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_side[g] <= side_in;
            end
        end
    end

endmodule

/* rtl/distance_constraint_projection_core.sv */
// Top level of the distance constraint projection pipeline.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+--------------------------------------------
//  input   | i_valid / o_ready  | i_pos_a_*, i_pos_b_*, i_mass_a/b, i_rest_length
//  output  | o_valid / i_ready  | o_new_a_*, o_new_b_*
//
// One pair is taken per cycle unless back-pressure stalls the input; the depth is set
// by the square root (one bit per stage) and the two 31-stage dividers.
// Reset clears every valid bit in the pipeline; payload registers are not reset.
// Each stage advances when its successor is empty or moving, so bubbles are squeezed
// out under back-pressure and a stalled transfer is neither lost nor repeated.
module distance_constraint_projection_core import dcp_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_pos_a_x,
    input  logic [COORD_WIDTH-1:0] i_pos_a_y,
    input  logic [COORD_WIDTH-1:0] i_pos_a_z,
    input  logic [COORD_WIDTH-1:0] i_pos_b_x,
    input  logic [COORD_WIDTH-1:0] i_pos_b_y,
    input  logic [COORD_WIDTH-1:0] i_pos_b_z,
    input  logic [COORD_WIDTH-2:0] i_mass_a,
    input  logic [COORD_WIDTH-2:0] i_mass_b,
    input  logic [COORD_WIDTH-2:0] i_rest_length,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH-1:0] o_new_a_x,
    output logic [COORD_WIDTH-1:0] o_new_a_y,
    output logic [COORD_WIDTH-1:0] o_new_a_z,
    output logic [COORD_WIDTH-1:0] o_new_b_x,
    output logic [COORD_WIDTH-1:0] o_new_b_y,
    output logic [COORD_WIDTH-1:0] o_new_b_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int RW  = CW + 1;              // length and difference magnitude width
    localparam int PW1 = RW + QuotW;          // |v| * |u| product width
    localparam int PW2 = PW1 + QuotW;         // product with the mass share

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0][CW:0]   dm;
        logic [2:0]         dneg;
        logic [CW-2:0]      ma;
        logic [CW-2:0]      mb;
        logic [CW-2:0]      rest;
    } t_front;

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0]         dneg;
        logic [CW-2:0]      ma;
        logic [CW-2:0]      mb;
        logic [CW-1:0]      msum;
        logic               mzero;
        logic               lzero;
        logic               vneg;
        logic [CW:0]        vm;
    } t_mid;

    typedef struct packed {
        logic [2:0][CW-1:0]    a;
        logic [2:0][CW-1:0]    b;
        logic [2:0]            dneg;
        logic                  mzero;
        logic                  lzero;
        logic                  vneg;
        logic [CW:0]           vm;
        logic [2:0][QuotW-1:0] u;
    } t_dirq;

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0]         neg;
        logic [QuotW-1:0]   ra;
        logic [QuotW-1:0]   rb;
    } t_mp;

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0]         neg;
    } t_mr;

    // Saturate a widened signed sum to the coordinate range.
    function automatic logic [CW-1:0] f_sat(input logic [CW+1:0] x);
        logic [2:0] top;
        top = x[CW+1:CW-1];
        if (top == 3'b000 || top == 3'b111) begin
            return x[CW-1:0];
        end
        return x[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic [CW-1:0] pa [3];
    logic [CW-1:0] pb [3];

    assign pa[0] = i_pos_a_x;
    assign pa[1] = i_pos_a_y;
    assign pa[2] = i_pos_a_z;
    assign pb[0] = i_pos_b_x;
    assign pb[1] = i_pos_b_y;
    assign pb[2] = i_pos_b_z;

    // ---------------- Stage 1: differences and their magnitudes ----------------
    t_front n_front, r_s1_ctx;
    logic   r_s1_v, rdy1, sq_rdy;

    always_comb begin
        logic [CW:0] dd;
        for (int i = 0; i < 3; i++) begin
            dd              = {pb[i][CW-1], pb[i]} - {pa[i][CW-1], pa[i]};
            n_front.a[i]    = pa[i];
            n_front.b[i]    = pb[i];
            n_front.dneg[i] = dd[CW];
            n_front.dm[i]   = dd[CW] ? (~dd + 1'b1) : dd;
        end
        n_front.ma   = i_mass_a;
        n_front.mb   = i_mass_b;
        n_front.rest = i_rest_length;
    end

    assign rdy1    = !r_s1_v || sq_rdy;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (rdy1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_ctx <= n_front;
        end
    end

    // ---------------- Squares of the differences ----------------
    logic                 sq_valid, rdy2;
    logic [3*2*RW-1:0]    sq_p;
    logic [$bits(t_front)-1:0] sq_side;
    t_front               sq_ctx;

    dcp_mul #(
        .LANES (3),
        .AW    (RW),
        .BW    (RW),
        .SW    ($bits(t_front))
    ) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v),
        .o_ready (sq_rdy),
        .i_a     (r_s1_ctx.dm),
        .i_b     (r_s1_ctx.dm),
        .i_side  (r_s1_ctx),
        .o_valid (sq_valid),
        .i_ready (rdy2),
        .o_p     (sq_p),
        .o_side  (sq_side)
    );

    assign sq_ctx = sq_side;

    // ---------------- Stage 2: squared length ----------------
    logic           r_s2_v, rt_rdy;
    logic [2*RW-1:0] r_s2_s;
    t_front         r_s2_ctx;

    assign rdy2 = !r_s2_v || rt_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (rdy2) begin
            r_s2_v <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && sq_valid) begin
            r_s2_s   <= sq_p[0 +: 2*RW] + sq_p[2*RW +: 2*RW] + sq_p[4*RW +: 2*RW];
            r_s2_ctx <= sq_ctx;
        end
    end

    // ---------------- Length ----------------
    logic          rt_valid, rdy3;
    logic [RW-1:0] rt_len;
    logic [$bits(t_front)-1:0] rt_side;
    t_front        rt_ctx;

    dcp_isqrt #(
        .RW (RW),
        .SW ($bits(t_front))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (rt_rdy),
        .i_s     (r_s2_s),
        .i_side  (r_s2_ctx),
        .o_valid (rt_valid),
        .i_ready (rdy3),
        .o_root  (rt_len),
        .o_side  (rt_side)
    );

    assign rt_ctx = rt_side;

    // ---------------- Stage 3: violation and mass sum ----------------
    t_mid               n_mid, r_s3_mid;
    logic               r_s3_v, du_rdy;
    logic [2:0][CW:0]   r_s3_dm;
    logic [RW-1:0]      r_s3_len;

    always_comb begin
        logic [CW+1:0] viol;
        viol        = {1'b0, rt_len} - {3'b000, rt_ctx.rest};
        n_mid.a     = rt_ctx.a;
        n_mid.b     = rt_ctx.b;
        n_mid.dneg  = rt_ctx.dneg;
        n_mid.ma    = rt_ctx.ma;
        n_mid.mb    = rt_ctx.mb;
        n_mid.msum  = {1'b0, rt_ctx.ma} + {1'b0, rt_ctx.mb};
        n_mid.mzero = (rt_ctx.ma == '0) && (rt_ctx.mb == '0);
        n_mid.lzero = (rt_len == '0);
        n_mid.vneg  = viol[CW+1];
        n_mid.vm    = viol[CW+1] ? RW'(~viol + 1'b1) : viol[CW:0];
    end

    assign rdy3 = !r_s3_v || du_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (rdy3) begin
            r_s3_v <= rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && rt_valid) begin
            r_s3_mid <= n_mid;
            r_s3_dm  <= rt_ctx.dm;
            r_s3_len <= rt_len;
        end
    end

    // ---------------- Unit direction ----------------
    logic                  du_valid, dq_rdy;
    logic [3*QuotW-1:0]    du_q;
    logic [$bits(t_mid)-1:0] du_side;
    t_mid                  du_ctx;
    t_dirq                 n_dirq;

    dcp_div #(
        .LANES (3),
        .NW    (RW),
        .DW    (RW),
        .SW    ($bits(t_mid))
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (du_rdy),
        .i_n     (r_s3_dm),
        .i_d     (r_s3_len),
        .i_side  (r_s3_mid),
        .o_valid (du_valid),
        .i_ready (dq_rdy),
        .o_q     (du_q),
        .o_side  (du_side)
    );

    assign du_ctx = du_side;

    always_comb begin
        n_dirq.a     = du_ctx.a;
        n_dirq.b     = du_ctx.b;
        n_dirq.dneg  = du_ctx.dneg;
        n_dirq.mzero = du_ctx.mzero;
        n_dirq.lzero = du_ctx.lzero;
        n_dirq.vneg  = du_ctx.vneg;
        n_dirq.vm    = du_ctx.vm;
        n_dirq.u     = du_q;
    end

    // ---------------- Mass shares: lane 0 gives A's share, lane 1 gives B's ----------------
    logic                   dq_valid, mp_rdy;
    logic [2*QuotW-1:0]     dq_q;
    logic [$bits(t_dirq)-1:0] dq_side;
    t_dirq                  dq_ctx;

    dcp_div #(
        .LANES (2),
        .NW    (CW - 1),
        .DW    (CW),
        .SW    ($bits(t_dirq))
    ) u_div_mass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (du_valid),
        .o_ready (dq_rdy),
        .i_n     ({du_ctx.ma, du_ctx.mb}),
        .i_d     (du_ctx.msum),
        .i_side  (n_dirq),
        .o_valid (dq_valid),
        .i_ready (mp_rdy),
        .o_q     (dq_q),
        .o_side  (dq_side)
    );

    assign dq_ctx = dq_side;

    // Coincident particles use the fixed y direction; a zero mass sum moves nothing.
    logic [2:0][QuotW-1:0] u_eff;
    t_mp                   n_mp;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dq_ctx.lzero) begin
                u_eff[i] = (i == 1) ? QOne : '0;
            end else begin
                u_eff[i] = dq_ctx.u[i];
            end
            n_mp.neg[i] = dq_ctx.vneg ^ (dq_ctx.dneg[i] && !dq_ctx.lzero);
        end
        n_mp.a  = dq_ctx.a;
        n_mp.b  = dq_ctx.b;
        n_mp.ra = dq_ctx.mzero ? '0 : dq_q[0 +: QuotW];
        n_mp.rb = dq_ctx.mzero ? '0 : dq_q[QuotW +: QuotW];
    end

    // ---------------- |v| * |u| per axis ----------------
    logic                  mp_valid, mr_rdy;
    logic [3*PW1-1:0]      mp_p;
    logic [$bits(t_mp)-1:0] mp_side;
    t_mp                   mp_ctx;
    t_mr                   n_mr;

    dcp_mul #(
        .LANES (3),
        .AW    (RW),
        .BW    (QuotW),
        .SW    ($bits(t_mp))
    ) u_mul_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dq_valid),
        .o_ready (mp_rdy),
        .i_a     ({dq_ctx.vm, dq_ctx.vm, dq_ctx.vm}),
        .i_b     (u_eff),
        .i_side  (n_mp),
        .o_valid (mp_valid),
        .i_ready (mr_rdy),
        .o_p     (mp_p),
        .o_side  (mp_side)
    );

    assign mp_ctx = mp_side;

    always_comb begin
        n_mr.a   = mp_ctx.a;
        n_mr.b   = mp_ctx.b;
        n_mr.neg = mp_ctx.neg;
    end

    // ---------------- Weighting by mass share: lanes 0-2 for A, 3-5 for B ----------------
    logic                  mr_valid, rdyo;
    logic [6*PW2-1:0]      mr_p;
    logic [$bits(t_mr)-1:0] mr_side;
    t_mr                   mr_ctx;

    dcp_mul #(
        .LANES (6),
        .AW    (PW1),
        .BW    (QuotW),
        .SW    ($bits(t_mr))
    ) u_mul_mass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mp_valid),
        .o_ready (mr_rdy),
        .i_a     ({mp_p, mp_p}),
        .i_b     ({mp_ctx.rb, mp_ctx.rb, mp_ctx.rb, mp_ctx.ra, mp_ctx.ra, mp_ctx.ra}),
        .i_side  (n_mr),
        .o_valid (mr_valid),
        .i_ready (rdyo),
        .o_p     (mr_p),
        .o_side  (mr_side)
    );

    assign mr_ctx = mr_side;

    // ---------------- Output stage: apply the moves and saturate ----------------
    logic          r_o_v;
    logic [CW-1:0] r_new [6];
    logic [CW-1:0] n_new [6];

    always_comb begin
        logic [CW+1:0] sa, sb, mva, mvb;
        for (int i = 0; i < 3; i++) begin
            mva = (CW+2)'(mr_p[i*PW2 + 2*QFrac +: RW]);
            mvb = (CW+2)'(mr_p[(i+3)*PW2 + 2*QFrac +: RW]);
            sa  = {{2{mr_ctx.a[i][CW-1]}}, mr_ctx.a[i]};
            sb  = {{2{mr_ctx.b[i][CW-1]}}, mr_ctx.b[i]};
            n_new[i]   = f_sat(mr_ctx.neg[i] ? (sa - mva) : (sa + mva));
            n_new[i+3] = f_sat(mr_ctx.neg[i] ? (sb + mvb) : (sb - mvb));
        end
    end

    assign rdyo = !r_o_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdyo) begin
            r_o_v <= mr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdyo && mr_valid) begin
            r_new <= n_new;
        end
    end

    assign o_valid   = r_o_v;
    assign o_new_a_x = r_new[0];
    assign o_new_a_y = r_new[1];
    assign o_new_a_z = r_new[2];
    assign o_new_b_x = r_new[3];
    assign o_new_b_y = r_new[4];
    assign o_new_b_z = r_new[5];

endmodule

/* sim/dcp_checker.sv */
// Checker for the distance constraint projection core: predicts and compares results.
`timescale 1ns / 1ps

module dcp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_ready,
    input  logic [COORD_WIDTH-1:0] i_pos_a_x,
    input  logic [COORD_WIDTH-1:0] i_pos_a_y,
    input  logic [COORD_WIDTH-1:0] i_pos_a_z,
    input  logic [COORD_WIDTH-1:0] i_pos_b_x,
    input  logic [COORD_WIDTH-1:0] i_pos_b_y,
    input  logic [COORD_WIDTH-1:0] i_pos_b_z,
    input  logic [COORD_WIDTH-2:0] i_mass_a,
    input  logic [COORD_WIDTH-2:0] i_mass_b,
    input  logic [COORD_WIDTH-2:0] i_rest_length,
    input  logic                   i_out_valid,
    input  logic                   i_ready,
    input  logic [COORD_WIDTH-1:0] i_new_a_x,
    input  logic [COORD_WIDTH-1:0] i_new_a_y,
    input  logic [COORD_WIDTH-1:0] i_new_a_z,
    input  logic [COORD_WIDTH-1:0] i_new_b_x,
    input  logic [COORD_WIDTH-1:0] i_new_b_y,
    input  logic [COORD_WIDTH-1:0] i_new_b_z,
    output int                     o_errors,
    output int                     o_pending
);

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef struct packed {
        t_coord ax, ay, az, bx, by, bz;
    } t_pair_pos;

    t_pair_pos corrected_q[$];

    assign o_pending = corrected_q.size();

    // Clamp a wide signed value to the coordinate range.
    function automatic t_coord clamp_coord(input logic signed [127:0] x);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[COORD_WIDTH-1:0];
    endfunction

    // Project one pair onto its rest length.
    function automatic t_pair_pos project_pair(input t_coord ap[3], input t_coord bp[3],
                                               input logic [COORD_WIDTH-2:0] ma,
                                               input logic [COORD_WIDTH-2:0] mb,
                                               input logic [COORD_WIDTH-2:0] rest);
        logic signed [127:0] a[3], b[3], d[3], viol, na[3], nb[3];
        logic [127:0] sumsq, len, cand, vmag, share_a, share_b, dirmag[3], msum, mvA, mvB;
        logic dneg[3];
        t_pair_pos r;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = 128'(signed'(ap[i]));
            b[i] = 128'(signed'(bp[i]));
            d[i] = b[i] - a[i];
            dneg[i] = d[i] < 0;
            dirmag[i] = dneg[i] ? -d[i] : d[i];
            sumsq += dirmag[i] * dirmag[i];
        end
        len = 0;
        for (int k = 55; k >= 0; k--) begin
            cand = len | (128'd1 << k);
            if (cand * cand <= sumsq) len = cand;
        end
        viol = $signed(len) - $signed({97'd0, rest});
        vmag = viol < 0 ? -viol : viol;
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                dirmag[i] = (i == 1) ? (128'd1 << 30) : 0;
                dneg[i] = 1'b0;
            end else begin
                dirmag[i] = (dirmag[i] << 30) / len;
            end
        end
        msum = ma + mb;
        share_a = msum == 0 ? 0 : ({97'd0, mb} << 30) / msum;
        share_b = msum == 0 ? 0 : ({97'd0, ma} << 30) / msum;
        for (int i = 0; i < 3; i++) begin
            mvA = (vmag * dirmag[i] * share_a) >> 60;
            mvB = (vmag * dirmag[i] * share_b) >> 60;
            if ((viol < 0) != dneg[i] && dirmag[i] != 0) begin
                na[i] = a[i] - $signed(mvA);
                nb[i] = b[i] + $signed(mvB);
            end else begin
                na[i] = a[i] + $signed(mvA);
                nb[i] = b[i] - $signed(mvB);
            end
        end
        r.ax = clamp_coord(na[0]);
        r.ay = clamp_coord(na[1]);
        r.az = clamp_coord(na[2]);
        r.bx = clamp_coord(nb[0]);
        r.by = clamp_coord(nb[1]);
        r.bz = clamp_coord(nb[2]);
        return r;
    endfunction

    // Compare one field and report a mismatch.
    task automatic check_field(input string name, input t_coord want, input t_coord got);
        if (want !== got) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    // Record each input transfer and check each output transfer.
    always @(posedge i_clk) begin
        t_pair_pos want;
        if (i_rst_n && i_valid && i_in_ready)
            corrected_q.push_back(project_pair('{i_pos_a_x, i_pos_a_y, i_pos_a_z},
                '{i_pos_b_x, i_pos_b_y, i_pos_b_z}, i_mass_a, i_mass_b, i_rest_length));
        if (i_rst_n && i_out_valid && i_ready) begin
            if (corrected_q.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, i_new_a_x);
                o_errors++;
            end else begin
                want = corrected_q.pop_front();
                check_field("new_a_x", want.ax, i_new_a_x);
                check_field("new_a_y", want.ay, i_new_a_y);
                check_field("new_a_z", want.az, i_new_a_z);
                check_field("new_b_x", want.bx, i_new_b_x);
                check_field("new_b_y", want.by, i_new_b_y);
                check_field("new_b_z", want.bz, i_new_b_z);
            end
        end
    end

endmodule

/* sim/tb_distance_constraint_projection_core.sv */
// Testbench top for the distance constraint projection core: stimulus and verdict.
`timescale 1ns / 1ps

module tb_distance_constraint_projection_core;

    localparam int CW = 32;
    localparam int N_RANDOM = 1300;
    localparam int HOLD_CYCLES = 400;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [CW-1:0] i_pos_a_x, i_pos_a_y, i_pos_a_z, i_pos_b_x, i_pos_b_y, i_pos_b_z;
    logic [CW-2:0] i_mass_a, i_mass_b, i_rest_length;
    logic [CW-1:0] o_new_a_x, o_new_a_y, o_new_a_z, o_new_b_x, o_new_b_y, o_new_b_z;
    int errors, pending;
    bit calm, hold;

    distance_constraint_projection_core #(.COORD_WIDTH(CW)) dut (.*);

    dcp_checker #(.COORD_WIDTH(CW)) u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready),
        .i_pos_a_x, .i_pos_a_y, .i_pos_a_z, .i_pos_b_x, .i_pos_b_y, .i_pos_b_z,
        .i_mass_a, .i_mass_b, .i_rest_length,
        .i_out_valid(o_valid), .i_ready,
        .i_new_a_x(o_new_a_x), .i_new_a_y(o_new_a_y), .i_new_a_z(o_new_a_z),
        .i_new_b_x(o_new_b_x), .i_new_b_y(o_new_b_y), .i_new_b_z(o_new_b_z),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net on the run length.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Random coordinate: sometimes an extreme, often small, otherwise anything.
    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2, 3, 4: return CW'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CW-2:0] pick_mag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: return (CW-1)'($urandom_range(0, 32'h00FF_FFFF));
            default: return (CW-1)'($urandom());
        endcase
    endfunction

    // Offer one pair and hold it until the transfer.
    task automatic send_pair(input logic [CW-1:0] ax, ay, az, bx, by, bz,
                             input logic [CW-2:0] ma, mb, rest);
        while (!calm && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_pos_a_x, i_pos_a_y, i_pos_a_z} <= {ax, ay, az};
        {i_pos_b_x, i_pos_b_y, i_pos_b_z} <= {bx, by, bz};
        {i_mass_a, i_mass_b, i_rest_length} <= {ma, mb, rest};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold && (calm || $urandom_range(0, 99) >= 18);
    end

    initial begin
        logic [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        i_rst_n = 1'b0; i_valid = 1'b0; calm = 1'b0; hold = 1'b0;
        {i_pos_a_x, i_pos_a_y, i_pos_a_z, i_pos_b_x, i_pos_b_y, i_pos_b_z} = '0;
        {i_mass_a, i_mass_b, i_rest_length} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coincident pair, zero masses, extremes and saturation.
        send_pair(0, 0, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000, 31'h2_0000);
        send_pair(5, 6, 7, 5, 6, 7, 0, 0, '1);
        send_pair(0, 0, 0, 32'h3_0000, 32'h4_0000, 0, 0, 0, 31'h1_0000);
        send_pair(0, 0, 0, 32'h3_0000, 32'h4_0000, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000);
        send_pair(0, 0, 0, 32'h3_0000, 32'h4_0000, 0, 31'h1_0000, 0, '1);
        send_pair(0, 0, 0, 32'h3_0000, 32'h4_0000, 0, 0, 31'h1_0000, 0);
        send_pair(mn, mn, mn, mx, mx, mx, '1, '1, 0);
        send_pair(mx, mx, mx, mn, mn, mn, '1, 1, 0);
        send_pair(mn, mn, mn, mx, mx, mx, 1, '1, '1);
        send_pair(mx, mn, 0, mn, mx, 0, '1, '1, '1);
        send_pair(mx, mx, mx, mx, mx, mx, '1, '1, '1);
        send_pair(mn, mn, mn, mn, mn, mn, 0, 1, '1);
        send_pair(32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h1234, 31'h5678, 31'h8000);
        send_pair(0, 0, 32'h7FFF_0000, 0, 0, 32'h8001_0000, '1, 0, 31'h1_0000);
        send_pair('1, '1, '1, 0, 0, 0, 1, 1, 0);

        // Random pairs; one quiet stretch and one long receiver hold-off.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) calm = 1'b1;
            if (n == 500) calm = 1'b0;
            if (n == 700) hold = 1'b1;
            send_pair(pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(),
                      pick_mag(), pick_mag(), pick_mag());
            if (n == 700) fork
                begin
                    int k;
                    for (k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                    hold = 1'b0;
                end
            join_none
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
